// File: design/rmat_pkg.sv
// rmat_pkg: constants, node type and sequencer states for the range max tree.
// Used by range_max_argmax_tree_top; depends on nothing.
package rmat_pkg;

  localparam int LEAVES = 1024;
  localparam int LEVELS = (LEAVES < 2) ? 1 : $clog2(LEAVES);
  localparam int SPAN   = 1 << LEVELS;
  localparam int NODES  = 2 * SPAN;
  localparam int NODE_W = LEVELS + 1;
  localparam int WALK_W = NODE_W + 1;
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 31;

  localparam logic signed [VAL_W-1:0] SENTINEL = -(VAL_W'(1) << 30);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        pos;
  } node_t;

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_WUP  = 5'b00100,
    S_QA   = 5'b01000,
    S_QB   = 5'b10000
  } state_t;

endpackage

// File: design/range_max_argmax_tree_top.sv
// range_max_argmax_tree_top: max tree over the leaves with write and range query.
// Node store is one memory in this module; types and constants from rmat_pkg.
//
//  channel | direction | handshake          | fields
//  in_     | in        | in_valid/in_stall  | command, leaf_index, new_value,
//          |           |                    | range_low, range_high
//  out_    | out       | out_valid/out_stall| max_value, max_position, found
//
// Write: one tree level per cycle, from the leaf up to the root, using the
// separate read and write ports of the node memory. Query: each level takes
// an S_QA and an S_QB step, each reading at most one node in turn through
// the read port, and the result is set up in S_QA.
// After reset a clearing pass writes all NODES (2048) nodes of the store.
// A query waits at its end while a previous result is still held by out_stall.
module range_max_argmax_tree_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [rmat_pkg::IDX_W-1:0]      in_leaf_index,
  input  logic signed [rmat_pkg::VAL_W-1:0] in_new_value,
  input  logic [rmat_pkg::IDX_W-1:0]      in_range_low,
  input  logic [rmat_pkg::IDX_W-1:0]      in_range_high,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [rmat_pkg::VAL_W-1:0] out_max_value,
  output logic [rmat_pkg::IDX_W-1:0]      out_max_position,
  output logic                            out_found
);

  localparam int NODE_W = rmat_pkg::NODE_W;
  localparam int WALK_W = rmat_pkg::WALK_W;
  localparam int IDX_W  = rmat_pkg::IDX_W;
  localparam int VAL_W  = rmat_pkg::VAL_W;

  function automatic logic [IDX_W-1:0] leaf_of(input logic [NODE_W-1:0] k);
    logic [NODE_W-1:0] t;
    int                msb;
    msb = 0;
    for (int i = 0; i < NODE_W; i++) begin
      if (k[i]) msb = i;
    end
    t = (k << (NODE_W - 1 - msb)) | ({NODE_W{1'b1}} >> (msb + 1));
    return t[IDX_W-1:0];
  endfunction

  rmat_pkg::node_t mem_r [rmat_pkg::NODES];
  rmat_pkg::node_t rd_data_r;

  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  rmat_pkg::node_t   wr_data;
  logic [NODE_W-1:0] rd_addr;

  rmat_pkg::state_t  state_r, state_nxt;
  logic [NODE_W-1:0] clr_r, clr_nxt;
  logic [NODE_W-1:0] wk_r, wk_nxt;
  rmat_pkg::node_t   cur_r, cur_nxt;
  logic [WALK_W-1:0] qa_r, qa_nxt, qb_r, qb_nxt;
  logic              pend_r, pend_nxt;
  logic              have_r, have_nxt;
  logic signed [VAL_W-1:0] bv_r, bv_nxt;
  logic [IDX_W-1:0]  bp_r, bp_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [IDX_W-1:0]        out_pos_r, out_pos_nxt;
  logic                    out_found_r, out_found_nxt;

  logic signed [VAL_W-1:0] bv_t;
  logic [IDX_W-1:0]        bp_t;
  logic                    have_t;
  logic                    better;
  logic [IDX_W-1:0]        hi_c;
  logic                    pick_sib;
  rmat_pkg::node_t         parent;
  logic [NODE_W-1:0]       pk;
  logic [NODE_W-1:0]       leaf_k;
  logic                    in_acc;

  assign in_stall = (state_r != rmat_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign hi_c   = (in_range_high > IDX_W'(rmat_pkg::LEAVES - 1)) ?
                  IDX_W'(rmat_pkg::LEAVES - 1) : in_range_high;
  assign leaf_k = NODE_W'(rmat_pkg::SPAN) + NODE_W'(in_leaf_index);

  assign better = !have_r || (rd_data_r.value > bv_r) ||
                  ((rd_data_r.value == bv_r) && (rd_data_r.pos > bp_r));

  always_comb begin
    bv_t   = bv_r;
    bp_t   = bp_r;
    have_t = have_r;
    if (pend_r && better) begin
      bv_t   = rd_data_r.value;
      bp_t   = rd_data_r.pos;
      have_t = 1'b1;
    end
  end

  assign pick_sib = wk_r[0] ? (rd_data_r.value > cur_r.value)
                            : !(cur_r.value > rd_data_r.value);
  assign parent   = pick_sib ? rd_data_r : cur_r;
  assign pk       = wk_r >> 1;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    wk_nxt        = wk_r;
    cur_nxt       = cur_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    pend_nxt      = 1'b0;
    have_nxt      = have_t;
    bv_nxt        = bv_t;
    bp_nxt        = bp_t;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_addr       = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_pos_nxt   = out_pos_r;
    out_found_nxt = out_found_r;
    case (state_r)
      rmat_pkg::S_CLR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_r;
        wr_data.value = rmat_pkg::SENTINEL;
        wr_data.pos   = (clr_r == '0) ? '0 : leaf_of(clr_r);
        clr_nxt       = clr_r + 1'b1;
        if (clr_r == NODE_W'(rmat_pkg::NODES - 1)) state_nxt = rmat_pkg::S_IDLE;
      end
      rmat_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_command == rmat_pkg::CMD_WRITE) begin
            if ({1'b0, in_leaf_index} < (IDX_W + 1)'(rmat_pkg::LEAVES)) begin
              wr_en         = 1'b1;
              wr_addr       = leaf_k;
              wr_data.value = in_new_value;
              wr_data.pos   = in_leaf_index;
              rd_addr       = leaf_k ^ NODE_W'(1);
              wk_nxt        = leaf_k;
              cur_nxt       = wr_data;
              state_nxt     = rmat_pkg::S_WUP;
            end
          end else begin
            have_nxt = 1'b0;
            bv_nxt   = rmat_pkg::SENTINEL;
            bp_nxt   = '0;
            if (in_range_low <= hi_c) begin
              qa_nxt = WALK_W'(rmat_pkg::SPAN) + WALK_W'(in_range_low);
              qb_nxt = WALK_W'(rmat_pkg::SPAN) + WALK_W'(hi_c) + WALK_W'(1);
            end else begin
              qa_nxt = '0;
              qb_nxt = '0;
            end
            state_nxt = rmat_pkg::S_QA;
          end
        end
      end
      rmat_pkg::S_WUP: begin
        wr_en   = 1'b1;
        wr_addr = pk;
        wr_data = parent;
        cur_nxt = parent;
        wk_nxt  = pk;
        rd_addr = pk ^ NODE_W'(1);
        if (pk == NODE_W'(1)) state_nxt = rmat_pkg::S_IDLE;
      end
      rmat_pkg::S_QA: begin
        if (qa_r < qb_r) begin
          if (qa_r[0]) begin
            rd_addr  = qa_r[NODE_W-1:0];
            pend_nxt = 1'b1;
            qa_nxt   = qa_r + 1'b1;
          end
          state_nxt = rmat_pkg::S_QB;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = bv_t;
          out_pos_nxt   = have_t ? bp_t : '0;
          out_found_nxt = have_t;
          state_nxt     = rmat_pkg::S_IDLE;
        end
      end
      rmat_pkg::S_QB: begin
        if (qb_r[0]) begin
          rd_addr  = NODE_W'(qb_r - 1'b1);
          pend_nxt = 1'b1;
        end
        qa_nxt    = qa_r >> 1;
        qb_nxt    = qb_r >> 1;
        state_nxt = rmat_pkg::S_QA;
      end
      default: begin
        state_nxt = rmat_pkg::S_CLR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    rd_data_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmat_pkg::S_CLR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wk_r        <= wk_nxt;
    cur_r       <= cur_nxt;
    qa_r        <= qa_nxt;
    qb_r        <= qb_nxt;
    have_r      <= have_nxt;
    bv_r        <= bv_nxt;
    bp_r        <= bp_nxt;
    out_value_r <= out_value_nxt;
    out_pos_r   <= out_pos_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_max_value    = out_value_r;
  assign out_max_position = out_pos_r;
  assign out_found        = out_found_r;

  a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmat_pkg::S_CLR) |-> in_stall)
    else $error("item taken during clearing pass");

  a_pend_query: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == rmat_pkg::S_QA || state_r == rmat_pkg::S_QB))
    else $error("pending node read outside a query");

  a_walk_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmat_pkg::S_WUP) |-> (wk_r > NODE_W'(1)))
    else $error("update walk past the root");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |->
      (out_pos_r == '0 && out_value_r == rmat_pkg::SENTINEL))
    else $error("empty range result not at sentinel");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rmat_pkg::S_QA))
    else $error("result raised outside query end");

endmodule
